>>> design/ac3sf_pkg.sv
// Package for the AC-3 sync frame assembler.
// Holds the burst and result types, the sync constants and the frame length table.
// No dependencies.
package ac3sf_pkg;

    localparam logic [15:0] C_SYNC_WORD  = 16'h0b77;
    localparam logic [15:0] C_SYNC_IDLE  = 16'hffff;
    localparam logic [7:0]  C_SYNC_HI    = 8'h0b;
    localparam logic [7:0]  C_SYNC_LO    = 8'h77;
    localparam logic [7:0]  C_BSID_LIMIT = 8'h60;
    localparam logic [5:0]  C_CODE_LIMIT = 6'd38;
    localparam logic [1:0]  C_FS_48K     = 2'd0;
    localparam logic [1:0]  C_FS_44K     = 2'd1;
    localparam logic [1:0]  C_FS_32K     = 2'd2;
    localparam logic [2:0]  C_HDR_BYTES  = 3'd6;

    typedef struct packed {
        logic             emit;
        logic             hdr;
        logic             last;
        logic [11:0]      len;
        logic [5:0][7:0]  bytes;
    } t_burst;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_first;
        logic        frame_last;
        logic [11:0] frame_bytes;
        logic        run_end;
    } t_result;

    function automatic logic [9:0] kbps(input logic [4:0] idx);
        logic [9:0] r;
        case (idx)
            5'd0:    r = 10'd32;
            5'd1:    r = 10'd40;
            5'd2:    r = 10'd48;
            5'd3:    r = 10'd56;
            5'd4:    r = 10'd64;
            5'd5:    r = 10'd80;
            5'd6:    r = 10'd96;
            5'd7:    r = 10'd112;
            5'd8:    r = 10'd128;
            5'd9:    r = 10'd160;
            5'd10:   r = 10'd192;
            5'd11:   r = 10'd224;
            5'd12:   r = 10'd256;
            5'd13:   r = 10'd320;
            5'd14:   r = 10'd384;
            5'd15:   r = 10'd448;
            5'd16:   r = 10'd512;
            5'd17:   r = 10'd576;
            5'd18:   r = 10'd640;
            default: r = 10'd0;
        endcase
        return r;
    endfunction

    // Words per frame at 44.1 kHz before the padding word: floor(320 * kbps / 147).
    function automatic logic [10:0] words_44k(input logic [4:0] idx);
        logic [10:0] w;
        case (idx)
            5'd0:    w = 11'd69;
            5'd1:    w = 11'd87;
            5'd2:    w = 11'd104;
            5'd3:    w = 11'd121;
            5'd4:    w = 11'd139;
            5'd5:    w = 11'd174;
            5'd6:    w = 11'd208;
            5'd7:    w = 11'd243;
            5'd8:    w = 11'd278;
            5'd9:    w = 11'd348;
            5'd10:   w = 11'd417;
            5'd11:   w = 11'd487;
            5'd12:   w = 11'd557;
            5'd13:   w = 11'd696;
            5'd14:   w = 11'd835;
            5'd15:   w = 11'd975;
            5'd16:   w = 11'd1114;
            5'd17:   w = 11'd1253;
            5'd18:   w = 11'd1393;
            default: w = 11'd0;
        endcase
        return w;
    endfunction

    // Frame length in bytes; zero marks an invalid header.
    function automatic logic [11:0] frame_len(input logic [7:0] b4, input logic [7:0] b5);
        logic [5:0]  code;
        logic [9:0]  rate;
        logic [11:0] len;
        code = b4[5:0];
        rate = kbps(code[5:1]);
        if (b5 >= C_BSID_LIMIT || code >= C_CODE_LIMIT) begin
            len = 12'd0;
        end else begin
            case (b4[7:6])
                C_FS_48K: len = {rate, 2'b00};
                C_FS_44K: len = {words_44k(code[5:1]) + {10'd0, code[0]}, 1'b0};
                C_FS_32K: len = {rate, 2'b00} + {1'b0, rate, 1'b0};
                default:  len = 12'd0;
            endcase
        end
        return len;
    endfunction

endpackage

>>> design/ac3sf_if.sv
// Stream channels of the AC-3 sync frame assembler.
// Input byte channel and result channel; depends on nothing.
interface ac3sf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface ac3sf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        frame_first;
    logic        frame_last;
    logic [11:0] frame_bytes;
    logic        run_end;

    modport source (output valid, output out_byte, output frame_first, output frame_last,
                    output frame_bytes, output run_end, input ready);
    modport sink   (input valid, input out_byte, input frame_first, input frame_last,
                    input frame_bytes, input run_end, output ready);
endinterface

>>> design/ac3sf_parser.sv
// Sync hunt, header check and frame body tracking for the AC-3 sync frame assembler.
// Uses ac3sf_pkg for the burst type, sync constants and frame length table.
module ac3sf_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output ac3sf_pkg::t_burst o_burst
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    logic [15:0] r_sync, n_sync;
    logic [1:0]  r_phase, n_phase;
    logic [11:0] r_pos, n_pos;
    logic [11:0] r_flen, n_flen;
    logic [23:0] r_hold, n_hold;
    logic [11:0] hdr_len;
    logic        body_last;

    assign hdr_len   = ac3sf_pkg::frame_len(r_hold[7:0], i_byte);
    assign body_last = ({1'b0, r_pos} + 13'd1) >= {1'b0, r_flen};

    always_comb begin
        n_sync  = r_sync;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_flen  = r_flen;
        n_hold  = r_hold;
        o_burst = '0;
        o_burst.len = r_flen;
        o_burst.bytes[0] = i_byte;
        case (r_phase)
            PH_HDR: begin
                if (r_pos < 12'd3) begin
                    n_hold = {r_hold[15:0], i_byte};
                    n_pos  = r_pos + 12'd1;
                end else if (hdr_len == 12'd0) begin
                    n_phase = PH_HUNT;
                    n_pos   = 12'd0;
                    n_sync  = ac3sf_pkg::C_SYNC_IDLE;
                end else begin
                    n_flen   = hdr_len;
                    n_phase  = PH_BODY;
                    n_pos    = {9'd0, ac3sf_pkg::C_HDR_BYTES};
                    o_burst.emit = 1'b1;
                    o_burst.hdr  = 1'b1;
                    o_burst.len  = hdr_len;
                    o_burst.bytes = {i_byte, r_hold[7:0], r_hold[15:8], r_hold[23:16],
                                     ac3sf_pkg::C_SYNC_LO, ac3sf_pkg::C_SYNC_HI};
                end
            end
            PH_BODY: begin
                o_burst.emit = 1'b1;
                o_burst.last = body_last;
                if (body_last) begin
                    n_phase = PH_HUNT;
                    n_pos   = 12'd0;
                    n_sync  = ac3sf_pkg::C_SYNC_IDLE;
                end else begin
                    n_pos = r_pos + 12'd1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
                n_sync  = {r_sync[7:0], i_byte};
                if (n_sync == ac3sf_pkg::C_SYNC_WORD) begin
                    n_phase = PH_HDR;
                    n_pos   = 12'd0;
                    n_hold  = 24'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync  <= ac3sf_pkg::C_SYNC_IDLE;
            r_phase <= PH_HUNT;
            r_pos   <= 12'd0;
            r_flen  <= 12'd0;
            r_hold  <= 24'd0;
        end else if (i_accept) begin
            r_sync  <= n_sync;
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_flen  <= n_flen;
            r_hold  <= n_hold;
        end
    end

endmodule

>>> design/ac3sf_emitter.sv
// Result register of the AC-3 sync frame assembler: holds a header burst or one body byte
// and hands it out one word per cycle while ready. Uses ac3sf_pkg for burst and result types.
module ac3sf_emitter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ac3sf_pkg::t_burst  i_burst,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_can_load,
    output ac3sf_pkg::t_result o_res
);

    logic [2:0]      r_cnt;
    logic            r_hdr;
    logic            r_last;
    logic [11:0]     r_len;
    logic [5:0][7:0] r_bytes;
    logic            take;
    logic            fill;

    assign o_valid    = r_cnt != 3'd0;
    assign take       = o_valid && i_ready;
    assign o_can_load = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_ready);
    assign fill       = i_load && i_burst.emit;

    assign o_res.out_byte    = r_bytes[0];
    assign o_res.frame_first = r_hdr && (r_cnt == ac3sf_pkg::C_HDR_BYTES);
    assign o_res.frame_last  = r_last && (r_cnt == 3'd1);
    assign o_res.frame_bytes = r_len;
    assign o_res.run_end     = r_cnt == 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (fill) begin
            r_cnt <= i_burst.hdr ? ac3sf_pkg::C_HDR_BYTES : 3'd1;
        end else if (take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fill) begin
            r_hdr   <= i_burst.hdr;
            r_last  <= i_burst.last;
            r_len   <= i_burst.len;
            r_bytes <= i_burst.bytes;
        end else if (take) begin
            r_bytes <= {8'h00, r_bytes[5:1]};
        end
    end

endmodule

>>> design/ac3_sync_frame_assembler.sv
// AC-3 sync frame assembler: hunts the 0x0B77 sync word, checks the header, streams frames.
// Latency: a body byte appears on the output the cycle after it is accepted.
// Throughput: one byte per cycle while the output is ready; a valid header gives a six-word
// burst that holds the input until its last word is taken. Synchronous active-low reset
// restarts the sync hunt. Depends on ac3sf_pkg, ac3sf_if, ac3sf_parser and ac3sf_emitter.
module ac3_sync_frame_assembler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ac3sf_in_if.sink    i_in,
    ac3sf_out_if.source o_out
);

    ac3sf_pkg::t_burst  burst;
    ac3sf_pkg::t_result res;
    logic               accept;
    logic               can_load;

    assign i_in.ready = can_load;
    assign accept     = i_in.valid && can_load;

    ac3sf_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.in_byte),
        .o_burst  (burst)
    );

    ac3sf_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_burst    (burst),
        .i_ready    (o_out.ready),
        .o_valid    (o_out.valid),
        .o_can_load (can_load),
        .o_res      (res)
    );

    assign o_out.out_byte    = res.out_byte;
    assign o_out.frame_first = res.frame_first;
    assign o_out.frame_last  = res.frame_last;
    assign o_out.frame_bytes = res.frame_bytes;
    assign o_out.run_end     = res.run_end;

endmodule
